@@ hw/rtl/blifo_pkg.sv @@
// Shared types and constants for the bounded LIFO stack.
`default_nettype none

package blifo_pkg;

	localparam int DEPTH_DEF = 8;
	localparam int CAP_W     = 4;
	localparam int WORD_W    = 32;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;
	localparam int OUT_W     = 72;

	// request codes
	localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_DISP = 2'd2;
	localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
	localparam logic [STAT_W-1:0] ST_OVERFLOW   = 2'd1;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW  = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY_DISP = 2'd3;

	localparam logic [CAP_W-1:0] CAP_RESET = 4'd8;

	typedef enum logic [2:0] {
		FSM_IDLE = 3'b001,
		FSM_POP  = 3'b010,
		FSM_DISP = 3'b100
	} fsm_t;

endpackage

`default_nettype wire

@@ hw/rtl/blifo_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module blifo_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/bounded_lifo_stack.sv @@
// Bounded LIFO stack of signed words with push, pop and top-to-bottom display.
//
// channel | dir | handshake         | payload
// s_*     | in  | s_tvalid/s_tready | tuser=req_type, tdata=push_value
// m_*     | out | m_tvalid/m_tready | tuser=status, tdata=item/top/flags, tlast
// cfg_*   | in  | cfg_valid/ready   | cfg_data=capacity
//
// Push, failed requests and a pop that empties the stack load their result directly from idle.
// Other pops wait in FSM_POP for the RAM read of the new top.
// Display walks the entries from top to bottom, one RAM read per entry.
// Reset empties the stack and sets capacity to 8; no clearing pass.
// A held result stalls the next request only when m_tready stays low.
`default_nettype none

module bounded_lifo_stack import blifo_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire logic [7:0]        s_tuser,  // [1:0] req_type
	input  wire logic [WORD_W-1:0] s_tdata,  // [31:0] push_value
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output logic [1:0]             m_tuser,  // [1:0] status
	output logic [OUT_W-1:0]       m_tdata,  // [31:0] item_value, [63:32] top_value,
	                                          // [64] is_empty, [65] is_full
	output logic                   m_tlast,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [CAP_W-1:0]  cfg_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	fsm_t              fsm_q;
	logic [CW-1:0]     count_q;
	logic [AW-1:0]     idx_q;
	logic [WORD_W-1:0] top_q;
	logic [CAP_W-1:0]  cap_q;

	logic              out_valid_q;
	logic [STAT_W-1:0] out_status_q;
	logic [WORD_W-1:0] out_item_q;
	logic [WORD_W-1:0] out_top_q;
	logic              out_empty_q;
	logic              out_full_q;
	logic              out_last_q;

	logic              ram_we;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [WORD_W-1:0] ram_rdata;

	logic              out_free;
	logic              accept;
	logic [EW-1:0]     eff_cap;
	logic              full_now;

	logic              load;
	logic [STAT_W-1:0] ld_status;
	logic [WORD_W-1:0] ld_item;
	logic              ld_last;
	logic [CW-1:0]     count_d;
	logic [WORD_W-1:0] top_d;
	logic [AW-1:0]     idx_d;
	fsm_t              fsm_d;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (fsm_q == FSM_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	// capacity zero acts as one, above DEPTH acts as DEPTH
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = EW'(1);
		end else if (EW'(cap_q) > EW'(DEPTH)) begin
			eff_cap = EW'(DEPTH);
		end else begin
			eff_cap = EW'(cap_q);
		end
	end
	assign full_now = EW'(count_q) >= eff_cap;

	always_comb begin
		load      = 1'b0;
		ld_status = ST_OK;
		ld_item   = '0;
		ld_last   = 1'b1;
		count_d   = count_q;
		top_d     = top_q;
		idx_d     = idx_q;
		fsm_d     = fsm_q;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = idx_q;
		unique case (fsm_q)
			FSM_IDLE: begin
				if (accept) begin
					unique case (s_tuser[REQ_W-1:0])
						REQ_PUSH: begin
							load = 1'b1;
							if (full_now) begin
								ld_status = ST_OVERFLOW;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
								top_d   = s_tdata;
							end
						end
						REQ_POP: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = ST_UNDERFLOW;
							end else if (count_q == CW'(1)) begin
								load    = 1'b1;
								count_d = '0;
							end else begin
								// new top comes from the RAM next cycle
								ram_re    = 1'b1;
								ram_raddr = AW'(count_q - CW'(2));
								count_d   = count_q - CW'(1);
								fsm_d     = FSM_POP;
							end
						end
						REQ_DISP: begin
							if (count_q == '0) begin
								load      = 1'b1;
								ld_status = ST_EMPTY_DISP;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = AW'(count_q - CW'(1));
								idx_d     = AW'(count_q - CW'(1));
								fsm_d     = FSM_DISP;
							end
						end
						REQ_NONE: begin
						end
						default: begin
						end
					endcase
				end
			end
			FSM_POP: begin
				if (out_free) begin
					load  = 1'b1;
					top_d = ram_rdata;
					fsm_d = FSM_IDLE;
				end
			end
			FSM_DISP: begin
				if (out_free) begin
					load    = 1'b1;
					ld_item = ram_rdata;
					ld_last = (idx_q == '0);
					if (idx_q == '0) begin
						fsm_d = FSM_IDLE;
					end else begin
						// prefetch the next entry down while this one leaves
						ram_re    = 1'b1;
						ram_raddr = idx_q - AW'(1);
						idx_d     = idx_q - AW'(1);
					end
				end
			end
			default: begin
				fsm_d = FSM_IDLE;
			end
		endcase
	end

	blifo_ram #(
		.WIDTH(WORD_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(count_q[AW-1:0]),
		.wdata(s_tdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q       <= FSM_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_RESET;
			out_valid_q <= 1'b0;
		end else begin
			fsm_q   <= fsm_d;
			count_q <= count_d;
			if (cfg_valid && cfg_ready) begin
				cap_q <= cfg_data;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		idx_q <= idx_d;
		if (load) begin
			out_status_q <= ld_status;
			out_item_q   <= ld_item;
			out_top_q    <= (count_d == '0) ? {WORD_W{1'b1}} : top_d;
			out_empty_q  <= (count_d == '0);
			out_full_q   <= EW'(count_d) >= eff_cap;
			out_last_q   <= ld_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {6'd0, out_full_q, out_empty_q, out_top_q, out_item_q};

endmodule

`default_nettype wire

@@ hw/rtl/blifo_checker.sv @@
// Port-level checks for the bounded LIFO stack, bound to the top level.
`default_nettype none

module blifo_checker import blifo_pkg::*; (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              m_tvalid,
	input wire logic              m_tready,
	input wire logic [1:0]        m_tuser,
	input wire logic [OUT_W-1:0]  m_tdata,
	input wire logic              m_tlast
);

	// a stalled result stays offered
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// empty stack always reports -1 on top
	a_empty_top: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[64] |-> m_tdata[63:32] == {WORD_W{1'b1}})
		else $error("empty stack with top not -1");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == ST_OVERFLOW |-> m_tdata[65] && m_tlast)
		else $error("overflow without full flag");

	a_unf_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_UNDERFLOW || m_tuser == ST_EMPTY_DISP)
		|-> m_tdata[64] && m_tlast && m_tdata[31:0] == '0)
		else $error("underflow or empty display on non-empty stack");

endmodule

bind bounded_lifo_stack blifo_checker u_blifo_checker (.*);

`default_nettype wire

@@ dv/bounded_lifo_stack_tb.sv @@
// Self-checking testbench for the bounded LIFO stack: directed table, then random phases.
module bounded_lifo_stack_tb;
	import blifo_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_DIRECTED   = 19;
	localparam int N_PHASES     = 8;
	localparam int PHASE_ITEMS  = 32;
	localparam int SETTLE_CYC   = 16;
	localparam int CYCLE_LIMIT  = 400000;

	typedef struct {
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] item_value;
		logic [WORD_W-1:0] top_value;
		logic              is_empty;
		logic              is_full;
		logic              last;
	} stack_result_t;

	typedef struct {
		logic [REQ_W-1:0]  req;
		logic [WORD_W-1:0] value;
		bit                typed;
		logic [STAT_W-1:0] status;
		logic [WORD_W-1:0] top;
		logic              empty;
		logic              full;
	} req_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [7:0]        s_tuser;   // [1:0] req_type
	logic [WORD_W-1:0] s_tdata;   // [31:0] push_value
	logic              m_tvalid;
	logic              m_tready;
	logic [1:0]        m_tuser;   // [1:0] status
	logic [OUT_W-1:0]  m_tdata;   // [31:0] item_value, [63:32] top_value, [64] is_empty,
	                              // [65] is_full
	logic              m_tlast;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [CAP_W-1:0]  cfg_data;

	// predictor state
	logic [WORD_W-1:0] stack_words [DEPTH_DEF];
	int unsigned       stack_count;
	logic [CAP_W-1:0]  cap_setting;
	stack_result_t     expected_results [$];

	int mismatch_cnt;
	int cycle_cnt;
	bit no_gaps;

	// rows with typed expectations hold one result each
	req_row_t directed_rows [N_DIRECTED] = '{
		'{REQ_POP,  32'h0,        1'b1, ST_UNDERFLOW,  32'hFFFFFFFF, 1'b1, 1'b0},
		'{REQ_DISP, 32'h0,        1'b1, ST_EMPTY_DISP, 32'hFFFFFFFF, 1'b1, 1'b0},
		'{REQ_NONE, 32'hFFFFFFFF, 1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_PUSH, 32'h7FFFFFFF, 1'b1, ST_OK,         32'h7FFFFFFF, 1'b0, 1'b0},
		'{REQ_PUSH, 32'h80000000, 1'b1, ST_OK,         32'h80000000, 1'b0, 1'b0},
		'{REQ_PUSH, 32'h0,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_PUSH, 32'hFFFFFFFF, 1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_PUSH, 32'h1,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_PUSH, 32'h55555555, 1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_PUSH, 32'hAAAAAAAA, 1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_PUSH, 32'd12345,    1'b1, ST_OK,         32'd12345,    1'b0, 1'b1},
		'{REQ_PUSH, 32'd999,      1'b1, ST_OVERFLOW,   32'd12345,    1'b0, 1'b1},
		'{REQ_DISP, 32'h0,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_NONE, 32'h0,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_POP,  32'h0,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_POP,  32'h0,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_DISP, 32'h0,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_PUSH, 32'hDEADBEEF, 1'b0, ST_OK,         32'h0,        1'b0, 1'b0},
		'{REQ_DISP, 32'h0,        1'b0, ST_OK,         32'h0,        1'b0, 1'b0}
	};

	bounded_lifo_stack #(.DEPTH(DEPTH_DEF)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tuser  (m_tuser),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int draw_gap();
		return no_gaps ? 0 : $urandom_range(0, 8);
	endfunction

	function automatic int unsigned usable_depth();
		int unsigned c;
		c = cap_setting;
		if (c == 0) c = 1;
		if (c > DEPTH_DEF) c = DEPTH_DEF;
		return c;
	endfunction

	function automatic logic [WORD_W-1:0] draw_word();
		case ($urandom_range(0, 5))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			3: return 32'hFFFFFFFF;
			default: return $urandom;
		endcase
	endfunction

	// queue one result seen against the stack state after the request
	task automatic expect_result(input logic [STAT_W-1:0] st, input logic [WORD_W-1:0] item,
			input logic lst);
		stack_result_t r;
		r.status     = st;
		r.item_value = item;
		r.top_value  = (stack_count == 0) ? 32'hFFFFFFFF : stack_words[stack_count-1];
		r.is_empty   = (stack_count == 0);
		r.is_full    = (stack_count >= usable_depth());
		r.last       = lst;
		expected_results.push_back(r);
	endtask

	task automatic stack_apply_request(input logic [REQ_W-1:0] rq, input logic [WORD_W-1:0] val);
		case (rq)
			REQ_PUSH: begin
				if (stack_count >= usable_depth()) begin
					expect_result(ST_OVERFLOW, '0, 1'b1);
				end else begin
					stack_words[stack_count] = val;
					stack_count++;
					expect_result(ST_OK, '0, 1'b1);
				end
			end
			REQ_POP: begin
				if (stack_count == 0) begin
					expect_result(ST_UNDERFLOW, '0, 1'b1);
				end else begin
					stack_count--;
					expect_result(ST_OK, '0, 1'b1);
				end
			end
			REQ_DISP: begin
				if (stack_count == 0) begin
					expect_result(ST_EMPTY_DISP, '0, 1'b1);
				end else begin
					for (int i = stack_count; i > 0; i--)
						expect_result(ST_OK, stack_words[i-1], i == 1);
				end
			end
			default: ;
		endcase
	endtask

	// called right after a rising edge; returns at the edge the transaction happens
	task automatic send_request(input logic [REQ_W-1:0] rq, input logic [WORD_W-1:0] val);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {6'b0, rq};
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		stack_apply_request(rq, val);
	endtask

	// drain all results, then let an ignored request finish
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] cap);
		cfg_valid <= 1'b1;
		cfg_data  <= cap;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cap_setting = cap;
	endtask

	task automatic compare_field(input string name, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatch_cnt++;
		end
	endtask

	// result side: random stalls, one check per transaction
	initial begin
		stack_result_t want;
		int stall;
		m_tready <= 1'b0;
		wait (arst_n);
		forever begin
			stall = draw_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (expected_results.size() == 0) begin
				$error("result with no request pending: status 0x%0h item 0x%0h",
					m_tuser, m_tdata[31:0]);
				mismatch_cnt++;
			end else begin
				want = expected_results.pop_front();
				compare_field("status",     want.status,     m_tuser);
				compare_field("item_value", want.item_value, m_tdata[31:0]);
				compare_field("top_value",  want.top_value,  m_tdata[63:32]);
				compare_field("is_empty",   want.is_empty,   m_tdata[64]);
				compare_field("is_full",    want.is_full,    m_tdata[65]);
				compare_field("last",       want.last,       m_tlast);
			end
		end
	end

	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("bounded_lifo_stack: mismatch");
		$finish;
	end

	initial begin
		stack_result_t typed_res;
		int unsigned   roll;
		int unsigned   push_share;
		logic [REQ_W-1:0] rq;

		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tuser   <= '0;
		s_tdata   <= '0;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		mismatch_cnt = 0;
		no_gaps      = 1'b0;
		stack_count  = 0;
		cap_setting  = CAP_RESET;
		foreach (stack_words[i]) stack_words[i] = '0;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].req, directed_rows[i].value);
			if (directed_rows[i].typed) begin
				typed_res.status     = directed_rows[i].status;
				typed_res.item_value = '0;
				typed_res.top_value  = directed_rows[i].top;
				typed_res.is_empty   = directed_rows[i].empty;
				typed_res.is_full    = directed_rows[i].full;
				typed_res.last       = 1'b1;
				void'(expected_results.pop_back());
				expected_results.push_back(typed_res);
			end
		end

		// first phases cover zero, above-depth, one and full depth;
		// the stack still holds entries, so capacity drops below the count
		for (int ph = 0; ph < N_PHASES; ph++) begin
			wait_idle();
			case (ph)
				0: write_capacity(4'd0);
				1: write_capacity(4'd15);
				2: write_capacity(4'd1);
				3: write_capacity(4'd8);
				default: write_capacity(CAP_W'($urandom_range(0, 15)));
			endcase
			no_gaps    = (ph == 1) || ($urandom_range(0, 2) == 0);
			push_share = $urandom_range(30, 60);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				roll = $urandom_range(0, 99);
				if (roll < 3)
					rq = REQ_NONE;
				else if (roll < 15)
					rq = REQ_DISP;
				else if (roll < 15 + push_share)
					rq = REQ_PUSH;
				else
					rq = REQ_POP;
				send_request(rq, draw_word());
			end
		end

		wait_idle();
		if (mismatch_cnt == 0)
			$display("bounded_lifo_stack: match");
		else
			$display("bounded_lifo_stack: mismatch");
		$finish;
	end

endmodule
